// ===== sv/json_lexer_stream_macros.svh =====
// ----------------------------------------------------------------------------
// json lexer stream assertion macros
// shared helpers for concurrent checks, clocked on i_clk, reset by i_rst_n
// ----------------------------------------------------------------------------
`ifndef JSON_LEXER_STREAM_MACROS_SVH
`define JSON_LEXER_STREAM_MACROS_SVH

// same-cycle implication
`define JLS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JLS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jls_pkg.sv =====
// ----------------------------------------------------------------------------
// jls_pkg
// types and constants shared by the json lexer stream modules
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_IDENT  = 2'd3
    } t_lex_mode;

    typedef enum logic [1:0] {
        EV_TEXT  = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } t_event_kind;

    localparam logic [3:0] TK_STRING        = 4'd0;
    localparam logic [3:0] TK_NUMBER        = 4'd1;
    localparam logic [3:0] TK_IDENT         = 4'd2;
    localparam logic [3:0] TK_COMMA         = 4'd3;
    localparam logic [3:0] TK_COLON         = 4'd4;
    localparam logic [3:0] TK_BRACE_OPEN    = 4'd5;
    localparam logic [3:0] TK_BRACE_CLOSE   = 4'd6;
    localparam logic [3:0] TK_BRACKET_OPEN  = 4'd7;
    localparam logic [3:0] TK_BRACKET_CLOSE = 4'd8;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_VALUE  = 2'd1;
    localparam logic [1:0] ERR_NUMBER = 2'd2;
    localparam logic [1:0] ERR_IDENT  = 2'd3;

    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_FORMFEED   = 8'h0C;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        t_event_kind event_kind;
        logic [3:0]  token_kind;
        logic [7:0]  char_value;
        logic [15:0] line_no;
        logic [15:0] column_no;
        logic [1:0]  error_code;
        logic        final_result;
    } t_out_beat;

    // all results caused by one accepted byte
    typedef struct packed {
        logic      two;
        t_out_beat first;
        t_out_beat second;
    } t_entry;

endpackage

`default_nettype wire

// ===== sv/jls_front.sv =====
// ----------------------------------------------------------------------------
// jls_front
// accepts text bytes, tracks position and lexer mode, builds result entries
// ----------------------------------------------------------------------------
`default_nettype none

module jls_front import jls_pkg::*; #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_beat i_data,
    output logic          o_push,
    input  wire logic     i_push_ready,
    output t_entry        o_entry
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    t_lex_mode                r_mode, n_mode;
    logic                     r_dq, n_dq;
    logic                     r_dot, n_dot;
    logic                     r_failed, n_failed;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;

    logic [7:0]               c;
    logic                     accept;
    logic                     is_digit, is_alpha, is_quote, is_punct, is_ws;
    logic [3:0]               punct_tk;
    logic [POSITION_BITS-1:0] pos_line, pos_col;
    logic [15:0]              rep_line, rep_col;

    t_lex_mode                lex_mode;
    logic                     lex_dq, lex_dot, lex_fail;

    t_out_beat                a0, a1, fl, r0, r1;
    logic [1:0]               lex_n, cnt;
    logic                     pend, flush;
    logic [3:0]               pend_tk;

    function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
        if (POSITION_BITS > 16 && v > POSITION_BITS'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return 16'(v);
    endfunction

    function automatic t_out_beat mk(input t_event_kind ev, input logic [3:0] tk,
                                     input logic [1:0] err, input logic [7:0] ch,
                                     input logic [15:0] ln, input logic [15:0] cl);
        t_out_beat b;
        b.event_kind   = ev;
        b.token_kind   = tk;
        b.char_value   = ch;
        b.line_no      = ln;
        b.column_no    = cl;
        b.error_code   = err;
        b.final_result = 1'b0;
        return b;
    endfunction

    assign c       = i_data.text_byte;
    assign o_ready = i_push_ready;
    assign accept  = i_valid && o_ready;

    // character classes
    always_comb begin
        is_digit = (c >= 8'h30) && (c <= 8'h39);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
        is_quote = (c == CH_BACKSLASH) || (c == CH_SQUOTE) || (c == CH_DQUOTE);
        is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
                   (c == CH_CR) || (c == CH_FORMFEED);
        is_punct = 1'b1;
        punct_tk = TK_COMMA;
        unique case (c)
            CH_COMMA:    punct_tk = TK_COMMA;
            CH_COLON:    punct_tk = TK_COLON;
            CH_LBRACE:   punct_tk = TK_BRACE_OPEN;
            CH_RBRACE:   punct_tk = TK_BRACE_CLOSE;
            CH_LBRACKET: punct_tk = TK_BRACKET_OPEN;
            CH_RBRACKET: punct_tk = TK_BRACKET_CLOSE;
            default:     is_punct = 1'b0;
        endcase
    end

    // position of the current byte
    always_comb begin
        pos_col  = (r_col != POS_MAX) ? r_col + POS_ONE : r_col;
        pos_line = r_line;
        if (c == CH_NEWLINE) begin
            pos_col  = POS_ONE;
            pos_line = (r_line != POS_MAX) ? r_line + POS_ONE : r_line;
        end
        rep_line = sat16(pos_line);
        rep_col  = sat16(pos_col);
    end

    // lexer mode after this byte, before any end-of-text flush
    always_comb begin
        lex_mode = r_mode;
        lex_dq   = r_dq;
        lex_dot  = r_dot;
        lex_fail = 1'b0;
        if (r_mode == MODE_STRING) begin
            if ((r_dq && c == CH_DQUOTE) || (!r_dq && c == CH_SQUOTE)) begin
                lex_mode = MODE_NONE;
            end
        end else if (is_quote) begin
            lex_mode = MODE_STRING;
            lex_dq   = (c == CH_DQUOTE);
        end else if (is_punct || is_ws) begin
            lex_mode = MODE_NONE;
        end else begin
            unique case (r_mode)
                MODE_NONE: begin
                    if (is_digit || c == CH_MINUS) begin
                        lex_mode = MODE_NUMBER;
                        lex_dot  = 1'b0;
                    end else if (is_alpha || c == CH_UNDERSCORE) begin
                        lex_mode = MODE_IDENT;
                    end else begin
                        lex_fail = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if ((!is_digit && c != CH_DOT) || (c == CH_DOT && r_dot)) begin
                        lex_fail = 1'b1;
                    end else if (c == CH_DOT) begin
                        lex_dot = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (!is_alpha && !is_digit && c != CH_UNDERSCORE) begin
                        lex_fail = 1'b1;
                    end
                end
                default: lex_mode = r_mode;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_dq     = r_dq;
        n_dot    = r_dot;
        n_failed = r_failed;
        n_line   = r_line;
        n_col    = r_col;
        if (accept) begin
            if (!r_failed) begin
                n_mode   = lex_mode;
                n_dq     = lex_dq;
                n_dot    = lex_dot;
                n_failed = lex_fail;
                n_line   = pos_line;
                n_col    = pos_col;
            end
            if (i_data.end_of_text) begin
                n_mode   = MODE_NONE;
                n_dq     = 1'b0;
                n_dot    = 1'b0;
                n_failed = 1'b0;
                n_line   = POS_ONE;
                n_col    = '0;
            end
        end
    end

    // results of this byte
    always_comb begin
        pend    = (r_mode == MODE_NUMBER) || (r_mode == MODE_IDENT);
        pend_tk = (r_mode == MODE_NUMBER) ? TK_NUMBER : TK_IDENT;
        a0      = mk(EV_TEXT, TK_STRING, ERR_NONE, c, rep_line, rep_col);
        a1      = a0;
        lex_n   = 2'd1;
        if (r_mode == MODE_STRING) begin
            if (lex_mode == MODE_NONE) begin
                a0 = mk(EV_END, TK_STRING, ERR_NONE, c, rep_line, rep_col);
            end
        end else if (is_quote || is_ws) begin
            a0    = mk(EV_END, pend_tk, ERR_NONE, c, rep_line, rep_col);
            lex_n = pend ? 2'd1 : 2'd0;
        end else if (is_punct) begin
            if (pend) begin
                a0    = mk(EV_END, pend_tk, ERR_NONE, c, rep_line, rep_col);
                a1    = mk(EV_END, punct_tk, ERR_NONE, c, rep_line, rep_col);
                lex_n = 2'd2;
            end else begin
                a0 = mk(EV_END, punct_tk, ERR_NONE, c, rep_line, rep_col);
            end
        end else if (lex_fail) begin
            unique case (r_mode)
                MODE_NUMBER: a0 = mk(EV_ERROR, TK_STRING, ERR_NUMBER, c, rep_line, rep_col);
                MODE_IDENT:  a0 = mk(EV_ERROR, TK_STRING, ERR_IDENT, c, rep_line, rep_col);
                default:     a0 = mk(EV_ERROR, TK_STRING, ERR_VALUE, c, rep_line, rep_col);
            endcase
        end else begin
            a0 = mk(EV_TEXT, (lex_mode == MODE_NUMBER) ? TK_NUMBER : TK_IDENT,
                    ERR_NONE, c, rep_line, rep_col);
        end

        // end of text closes a pending number or identifier
        flush = i_data.end_of_text && !lex_fail &&
                ((lex_mode == MODE_NUMBER) || (lex_mode == MODE_IDENT));
        fl    = mk(EV_END, (lex_mode == MODE_NUMBER) ? TK_NUMBER : TK_IDENT,
                   ERR_NONE, c, rep_line, rep_col);

        r0 = a0;
        r1 = a1;
        if (flush) begin
            if (lex_n == 2'd0) begin
                r0 = fl;
            end else begin
                r1 = fl;
            end
        end
        cnt = r_failed ? 2'd0 : lex_n + {1'b0, flush};
        if (cnt == 2'd2) begin
            r1.final_result = 1'b1;
        end else begin
            r0.final_result = 1'b1;
        end

        o_entry.two    = (cnt == 2'd2);
        o_entry.first  = r0;
        o_entry.second = r1;
        o_push         = accept && (cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NONE;
            r_dq     <= 1'b0;
            r_dot    <= 1'b0;
            r_failed <= 1'b0;
            r_line   <= POS_ONE;
            r_col    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_dq     <= n_dq;
            r_dot    <= n_dot;
            r_failed <= n_failed;
            r_line   <= n_line;
            r_col    <= n_col;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jls_queue.sv =====
// ----------------------------------------------------------------------------
// jls_queue
// short first-in first-out queue of result entries between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module jls_queue import jls_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    output logic        o_push_ready,
    input  wire t_entry i_entry,
    output logic        o_pop_valid,
    input  wire logic   i_pop,
    output t_entry      o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic                do_push, do_pop;

    assign o_push_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_entry      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jls_back.sv =====
// ----------------------------------------------------------------------------
// jls_back
// takes entries from the queue and hands out their results one beat at a time
// ----------------------------------------------------------------------------
`default_nettype none

module jls_back import jls_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_pop_valid,
    output logic        o_pop,
    input  wire t_entry i_entry,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_out_beat   o_data
);

    t_entry r_entry;
    logic   r_valid, n_valid;
    logic   r_second, n_second;
    logic   done;

    assign o_valid = r_valid;
    assign o_data  = r_second ? r_entry.second : r_entry.first;
    assign done    = r_valid && i_ready && (r_second || !r_entry.two);
    assign o_pop   = i_pop_valid && (!r_valid || done);

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        if (r_valid && i_ready && !done) begin
            n_second = 1'b1;
        end else if (!r_valid || done) begin
            n_valid  = i_pop_valid;
            n_second = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

endmodule

`default_nettype wire

// ===== sv/json_lexer_stream.sv =====
// ----------------------------------------------------------------------------
// json_lexer_stream
// streaming lexer for json-like text, one byte per beat in, result beats out
// ----------------------------------------------------------------------------
// path: each result is written into the queue memory, then loaded into the
//   back output register, from which it is offered
// throughput: one byte per cycle while the four-entry queue has room; a
//   byte with two results holds the output for both while the front goes on
// reset: synchronous, active low; lexer state to idle at line 1 column 0,
//   queue emptied, no result beat offered
`default_nettype none

`include "json_lexer_stream_macros.svh"

module json_lexer_stream import jls_pkg::*; #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_beat i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_beat     o_data
);

    // front to queue
    logic   push, push_ready;
    t_entry push_entry;

    // queue to back
    logic   pop_valid, pop;
    t_entry pop_entry;

    // front: classifies each byte against the current mode, updates the
    // saturating position and builds the whole set of results of that byte
    jls_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_entry      (push_entry)
    );

    // queue: decouples byte intake from result delivery
    jls_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_entry      (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_entry      (pop_entry)
    );

    // back: output register, serializes one or two results per entry
    jls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop       (pop),
        .i_entry     (pop_entry),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    // an error is always the last result of its byte
    `JLS_ASSERT_IMPL(a_error_is_final, o_valid && o_data.event_kind == EV_ERROR,
        o_data.final_result, "error beat not marked final")

    // the second result of a byte follows its first without a gap
    `JLS_ASSERT_NEXT(a_second_follows, o_valid && i_ready && !o_data.final_result,
        o_valid, "second result of a byte not offered next cycle")

    // token text only belongs to strings, numbers and identifiers
    `JLS_ASSERT_IMPL(a_text_token_kind, o_valid && o_data.event_kind == EV_TEXT,
        o_data.token_kind == TK_STRING || o_data.token_kind == TK_NUMBER ||
        o_data.token_kind == TK_IDENT, "text beat with punctuation kind")

endmodule

`default_nettype wire

// ===== dv/json_lexer_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_lexer_stream_checker
// watches both beat channels of the lexer, keeps its own copy of the lexer
// state, works out the result beats of every accepted byte and compares them
// field by field, in order, with the beats the block hands out
// ----------------------------------------------------------------------------

module json_lexer_stream_checker import jls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_beat   i_out_data,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    localparam logic [15:0] POS_LIMIT = 16'hFFFF;

    // lexer state as predicted
    t_lex_mode   mode      = MODE_NONE;
    logic        dquoted   = 1'b0;
    logic        dot_seen  = 1'b0;
    logic [15:0] line_cnt  = 16'd1;
    logic [15:0] col_cnt   = 16'd0;
    logic        stuck     = 1'b0;

    // result beats of the byte being predicted
    t_out_beat   byte_events [2];
    int          byte_event_cnt;

    t_out_beat   expected_events [$];
    t_out_beat   want;
    int unsigned mismatches = 0;

    function automatic logic is_dec_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic add_event(t_event_kind ev, logic [3:0] tk, logic [7:0] ch,
                             logic [1:0] err);
        t_out_beat r;
        r.event_kind   = ev;
        r.token_kind   = tk;
        r.char_value   = ch;
        r.line_no      = line_cnt;
        r.column_no    = col_cnt;
        r.error_code   = err;
        r.final_result = 1'b0;
        byte_events[byte_event_cnt] = r;
        byte_event_cnt++;
    endtask

    // a number or identifier in progress ends here
    task automatic close_token(logic [7:0] c);
        if (mode == MODE_NUMBER)
            add_event(EV_END, TK_NUMBER, c, ERR_NONE);
        else if (mode == MODE_IDENT)
            add_event(EV_END, TK_IDENT, c, ERR_NONE);
        mode = MODE_NONE;
    endtask

    // token kind reads as zero on an error
    task automatic flag_error(logic [7:0] c, logic [1:0] code);
        add_event(EV_ERROR, TK_STRING, c, code);
        stuck = 1'b1;
    endtask

    task automatic classify_byte(logic [7:0] c);
        logic [3:0] punct;
        logic       is_punct;
        is_punct = 1'b1;
        punct    = TK_STRING;
        if (mode == MODE_STRING) begin
            if ((dquoted && c == CH_DQUOTE) || (!dquoted && c == CH_SQUOTE)) begin
                add_event(EV_END, TK_STRING, c, ERR_NONE);
                mode = MODE_NONE;
            end else begin
                add_event(EV_TEXT, TK_STRING, c, ERR_NONE);
            end
            return;
        end
        case (c)
            CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE: begin
                close_token(c);
                mode    = MODE_STRING;
                dquoted = (c == CH_DQUOTE);
                return;
            end
            CH_COMMA:    punct = TK_COMMA;
            CH_COLON:    punct = TK_COLON;
            CH_LBRACE:   punct = TK_BRACE_OPEN;
            CH_RBRACE:   punct = TK_BRACE_CLOSE;
            CH_LBRACKET: punct = TK_BRACKET_OPEN;
            CH_RBRACKET: punct = TK_BRACKET_CLOSE;
            CH_SPACE, CH_TAB, CH_NEWLINE, CH_CR, CH_FORMFEED: begin
                close_token(c);
                return;
            end
            default: is_punct = 1'b0;
        endcase
        if (is_punct) begin
            close_token(c);
            add_event(EV_END, punct, c, ERR_NONE);
        end else if (mode == MODE_NONE) begin
            if (is_dec_digit(c) || c == CH_MINUS) begin
                mode     = MODE_NUMBER;
                dot_seen = 1'b0;
                add_event(EV_TEXT, TK_NUMBER, c, ERR_NONE);
            end else if (is_letter(c) || c == CH_UNDERSCORE) begin
                mode = MODE_IDENT;
                add_event(EV_TEXT, TK_IDENT, c, ERR_NONE);
            end else begin
                flag_error(c, ERR_VALUE);
            end
        end else if (mode == MODE_NUMBER) begin
            if ((!is_dec_digit(c) && c != CH_DOT) || (c == CH_DOT && dot_seen)) begin
                flag_error(c, ERR_NUMBER);
            end else begin
                if (c == CH_DOT)
                    dot_seen = 1'b1;
                add_event(EV_TEXT, TK_NUMBER, c, ERR_NONE);
            end
        end else begin
            if (!is_letter(c) && !is_dec_digit(c) && c != CH_UNDERSCORE)
                flag_error(c, ERR_IDENT);
            else
                add_event(EV_TEXT, TK_IDENT, c, ERR_NONE);
        end
    endtask

    // all result beats one accepted byte causes, queued in order
    task automatic tokenize_byte(t_in_beat b);
        byte_event_cnt = 0;
        if (!stuck) begin
            if (col_cnt != POS_LIMIT)
                col_cnt++;
            if (b.text_byte == CH_NEWLINE) begin
                if (line_cnt != POS_LIMIT)
                    line_cnt++;
                col_cnt = 16'd1;
            end
            classify_byte(b.text_byte);
            if (b.end_of_text && !stuck)
                close_token(b.text_byte);
        end
        if (byte_event_cnt > 0)
            byte_events[byte_event_cnt - 1].final_result = 1'b1;
        for (int i = 0; i < byte_event_cnt; i++)
            expected_events = {expected_events, byte_events[i]};
        if (b.end_of_text) begin
            mode     = MODE_NONE;
            dquoted  = 1'b0;
            dot_seen = 1'b0;
            line_cnt = 16'd1;
            col_cnt  = 16'd0;
            stuck    = 1'b0;
        end
    endtask

    task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    $error("result beat with nothing expected: event_kind %0d char_value %0d",
                           i_out_data.event_kind, i_out_data.char_value);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    compare_field("event_kind", want.event_kind, i_out_data.event_kind);
                    compare_field("token_kind", want.token_kind, i_out_data.token_kind);
                    compare_field("char_value", want.char_value, i_out_data.char_value);
                    compare_field("line_no", want.line_no, i_out_data.line_no);
                    compare_field("column_no", want.column_no, i_out_data.column_no);
                    compare_field("error_code", want.error_code, i_out_data.error_code);
                    compare_field("final_result", want.final_result,
                                  i_out_data.final_result);
                end
            end
            if (i_in_valid && i_in_ready)
                tokenize_byte(i_in_data);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_events.size();
    end

endmodule

// ===== dv/json_lexer_stream_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_lexer_stream_test
// drives text bytes into the lexer: a directed set of short texts, then
// random texts built mostly from well-formed tokens with some noise; the
// checker beside the block predicts and compares, and this module only
// drives and gives the verdict
// ----------------------------------------------------------------------------

module json_lexer_stream_test;
    import jls_pkg::*;

    localparam int RANDOM_BYTES   = 950;
    localparam int QUIET_TAIL     = 150;   // last random bytes sent with no idling
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_beat    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_beat   o_data;

    int unsigned chk_fail;
    int unsigned chk_pending;

    // idling switches for the byte source and the result sink
    bit          src_idle_en;
    bit          sink_idle_en;

    int          rand_sent;
    logic [7:0]  text_q [$];

    json_lexer_stream i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    json_lexer_stream_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (chk_fail),
        .o_pending    (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result sink: ready high, with random stall bursts while enabled
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // watchdog: a long stretch with no beat accepted on either side ends the run
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // one byte beat; valid stays high into the next beat unless a gap is taken
    task automatic send_beat(logic [7:0] c, logic is_last);
        t_in_beat beat;
        beat.text_byte   = c;
        beat.end_of_text = is_last;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // one byte onto the end of the pending text
    task automatic append_char(logic [7:0] c);
        text_q = {text_q, c};
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endtask

    // the queued text goes out with end_of_text on its last byte
    task automatic send_text();
        foreach (text_q[i]) begin
            send_beat(text_q[i], i == text_q.size() - 1);
            if (rand_sent >= 0)
                rand_sent++;
        end
        text_q.delete();
    endtask

    function automatic logic [7:0] punct_char(int unsigned k);
        case (k)
            0:       return CH_COMMA;
            1:       return CH_COLON;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_LBRACKET;
            default: return CH_RBRACKET;
        endcase
    endfunction

    function automatic logic [7:0] letter_char();
        if ($urandom_range(0, 1) == 0)
            return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // random text: mostly well-formed tokens, some broken ones and raw noise
    task automatic build_random_text();
        int unsigned sel;
        logic [7:0]  open_q;
        logic [7:0]  close_q;
        logic [7:0]  c;
        repeat ($urandom_range(1, 8)) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                // string, opened by either quote or a backslash
                case ($urandom_range(0, 2))
                    0:       open_q = CH_DQUOTE;
                    1:       open_q = CH_SQUOTE;
                    default: open_q = CH_BACKSLASH;
                endcase
                close_q = (open_q == CH_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
                append_char(open_q);
                repeat ($urandom_range(0, 4)) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == close_q)
                        c = "A";
                    append_char(c);
                end
                // now and then left open
                if ($urandom_range(0, 9) != 0)
                    append_char(close_q);
            end else if (sel < 55) begin
                if ($urandom_range(0, 2) == 0)
                    append_char(CH_MINUS);
                repeat ($urandom_range(1, 4)) append_char(digit_char());
                if ($urandom_range(0, 1) == 0) begin
                    append_char(CH_DOT);
                    repeat ($urandom_range(0, 3))
                        append_char(digit_char());
                end
                // broken number: a second dot
                if ($urandom_range(0, 14) == 0)
                    append_char(CH_DOT);
            end else if (sel < 75) begin
                append_char($urandom_range(0, 4) == 0 ? CH_UNDERSCORE : letter_char());
                repeat ($urandom_range(0, 4)) begin
                    case ($urandom_range(0, 2))
                        0:       append_char(letter_char());
                        1:       append_char(digit_char());
                        default: append_char(CH_UNDERSCORE);
                    endcase
                end
            end else if (sel < 90) begin
                append_char(punct_char($urandom_range(0, 5)));
            end else begin
                append_char(8'($urandom_range(0, 255)));
            end
            // separator after the token, whitespace or punctuation
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 6))
                    0:       append_char(CH_SPACE);
                    1:       append_char(CH_TAB);
                    2:       append_char(CH_NEWLINE);
                    3:       append_char(CH_CR);
                    4:       append_char(CH_FORMFEED);
                    default: append_char(punct_char($urandom_range(0, 5)));
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        rand_sent    = -1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every punctuation, single-quoted string, signed number with dot, ident
        push_str("{'k':[-1.,x_]}");
        send_text();
        // backslash opens a single-quoted string; pending number flushed at the end
        push_str("\\\"'7");
        send_text();
        // nul and 0xff are text inside a string, an error outside; then silence
        append_char(CH_DQUOTE);
        append_char(8'h00);
        append_char(8'hFF);
        append_char(CH_DQUOTE);
        append_char(8'hFF);
        push_str("a");
        send_text();
        // second dot in a number, no flush after the error
        push_str("1..");
        send_text();
        // newline, form feed closes an ident, bad ident char
        append_char(CH_NEWLINE);
        push_str("b");
        append_char(CH_FORMFEED);
        push_str("c$");
        send_text();
        // unterminated string dropped at the end
        push_str("\"q");
        send_text();
        // number closed by a comma on the final byte
        push_str("5,");
        send_text();

        // random texts; the tail runs with no idling on either side
        rand_sent = 0;
        while (rand_sent < RANDOM_BYTES) begin
            if (rand_sent >= RANDOM_BYTES - QUIET_TAIL) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            build_random_text();
            send_text();
        end
        i_valid <= 1'b0;

        // drain: every expected beat in, then a few more cycles for strays
        while (chk_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (chk_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
